### rtl/core/nms_pkg.sv
package nms_pkg;

    localparam int COORD_W       = 16;
    localparam int SCORE_W       = 16;
    localparam int IDX_W         = 6;
    localparam int AREA_W        = 2 * (COORD_W + 1);
    localparam int THR_W         = 16;
    localparam int PIPE_DEPTH    = 4;
    localparam int MAX_BOXES_DEF = 64;
    localparam int PADDR_W       = 2;
    localparam int PDATA_W       = 32;

    localparam logic [THR_W-1:0]   THR_RESET    = 16'd45875;
    localparam logic [PADDR_W-1:0] ADDR_OVERLAP = 2'd0;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_FLUSH
    } nms_state_t;

    // one box as it sits in the ring
    typedef struct packed {
        logic                     valid;
        logic [IDX_W-1:0]         idx;
        logic [SCORE_W-1:0]       score;
        logic [COORD_W-1:0]       lx;
        logic [COORD_W-1:0]       ty;
        logic [COORD_W-1:0]       rx;
        logic [COORD_W-1:0]       by;
        logic signed [AREA_W-1:0] area;
    } nms_entry_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } nms_cell_ctl_t;

endpackage

### rtl/core/nms_if.sv
interface nms_box_if;
    logic        valid;
    logic        ready;
    logic [15:0] left_x;
    logic [15:0] top_y;
    logic [15:0] right_x;
    logic [15:0] bottom_y;
    logic [15:0] score;
    logic        last_box;

    modport source (output valid, left_x, top_y, right_x, bottom_y, score, last_box,
                    input ready);
    modport sink   (input valid, left_x, top_y, right_x, bottom_y, score, last_box,
                    output ready);
endinterface

interface nms_res_if;
    logic       valid;
    logic       ready;
    logic [5:0] kept_index;
    logic       any_kept;
    logic       overflow;
    logic       last_result;

    modport source (output valid, kept_index, any_kept, overflow, last_result,
                    input ready);
    modport sink   (input valid, kept_index, any_kept, overflow, last_result,
                    output ready);
endinterface

### rtl/core/nms_cell.sv
module nms_cell
    import nms_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  nms_cell_ctl_t ctl,
    input  nms_entry_t    new_entry,
    input  nms_entry_t    prev_entry,
    input  logic          prev_keep,
    input  nms_entry_t    next_entry,
    output nms_entry_t    entry,
    output logic          keep
);

    nms_entry_t entry_reg, entry_next;
    logic       valid_reg;

    // stay put on insert when at least as strong as the newcomer
    assign keep = valid_reg && (entry_reg.score >= new_entry.score);

    always_comb
    begin
        entry_next = entry;
        if (ctl.insert && !keep)
        begin
            entry_next = prev_keep ? new_entry : prev_entry;
        end
        else if (ctl.shift)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
        end
    end

    always_comb
    begin
        entry       = entry_reg;
        entry.valid = valid_reg;
    end

endmodule

### rtl/core/nms_iou.sv
module nms_iou
    import nms_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [THR_W-1:0] threshold,
    input  nms_entry_t       leader,
    input  nms_entry_t       head,
    output nms_entry_t       tail
);

    localparam int INTER_W = 2 * COORD_W;
    localparam int SUM_W   = AREA_W + 1;
    localparam int UNI_W   = AREA_W + 2;
    localparam int LO_W    = 17;
    localparam int HI_W    = SUM_W - LO_W;
    localparam int PLO_W   = THR_W + LO_W;
    localparam int PHI_W   = THR_W + HI_W;
    localparam int PROD_W  = PHI_W + LO_W + 1;

    nms_entry_t e1_reg, e2_reg, e3_reg, e4_reg;
    logic [3:0] v_reg;

    logic [COORD_W-1:0]      w1_reg, h1_reg;
    logic [INTER_W-1:0]      inter2_reg, inter3_reg, inter4_reg;
    logic signed [SUM_W-1:0] sum2_reg;
    logic signed [UNI_W-1:0] uni3_reg;
    logic                    neg4_reg;
    logic [PLO_W-1:0]        plo4_reg;
    logic [PHI_W-1:0]        phi4_reg;

    logic [COORD_W-1:0]      mn_x, mx_x, mn_y, mx_y;
    logic signed [COORD_W:0] dw, dh;
    logic [PROD_W-1:0]       prod;
    logic                    suppress;

    always_comb
    begin
        mn_x = (leader.rx < head.rx) ? leader.rx : head.rx;
        mx_x = (leader.lx > head.lx) ? leader.lx : head.lx;
        mn_y = (leader.by < head.by) ? leader.by : head.by;
        mx_y = (leader.ty > head.ty) ? leader.ty : head.ty;
        dw   = $signed({1'b0, mn_x}) - $signed({1'b0, mx_x});
        dh   = $signed({1'b0, mn_y}) - $signed({1'b0, mx_y});
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            e1_reg     <= head;
            w1_reg     <= dw[COORD_W] ? '0 : dw[COORD_W-1:0];
            h1_reg     <= dh[COORD_W] ? '0 : dh[COORD_W-1:0];
            e2_reg     <= e1_reg;
            inter2_reg <= w1_reg * h1_reg;
            sum2_reg   <= $signed({leader.area[AREA_W-1], leader.area})
                        + $signed({e1_reg.area[AREA_W-1], e1_reg.area});
            e3_reg     <= e2_reg;
            inter3_reg <= inter2_reg;
            uni3_reg   <= $signed({sum2_reg[SUM_W-1], sum2_reg})
                        - $signed({{(UNI_W-INTER_W){1'b0}}, inter2_reg});
            e4_reg     <= e3_reg;
            inter4_reg <= inter3_reg;
            neg4_reg   <= uni3_reg[UNI_W-1];
            plo4_reg   <= threshold * uni3_reg[LO_W-1:0];
            phi4_reg   <= threshold * uni3_reg[SUM_W-1:LO_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[2:0], head.valid};
        end
    end

    // inter * 2^16 > threshold * union, for a non-negative union
    always_comb
    begin
        prod     = PROD_W'({phi4_reg, {LO_W{1'b0}}}) + PROD_W'(plo4_reg);
        suppress = !neg4_reg && (PROD_W'({inter4_reg, 16'h0000}) > prod);
        tail       = e4_reg;
        tail.valid = v_reg[3] && !suppress;
    end

endmodule

### rtl/core/non_maximum_suppression_unit.sv
// Greedy IoU non-maximum suppression. Boxes arrive one item at a time and are
// insertion-sorted by descending score (ties keep load order) into a row of
// MAX_BOXES cells; zero-area boxes are not stored and boxes beyond MAX_BOXES
// are dropped and flagged. The item with last_box starts the run: the cells
// and a four-stage IoU pipeline form a ring of MAX_BOXES+4 slots that turns
// one slot per cycle unless a blocked output holds it. In each full turn the
// first live box reaching the head is kept and every later live box is tested
// against it in the single shared IoU pipeline; the run ends after a turn
// that keeps no box. Kept indices leave in score order; an empty set gives
// one item with any_kept low. The threshold may be rewritten only while the
// block is idle.
module non_maximum_suppression_unit
    import nms_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    nms_box_if.sink            box,
    nms_res_if.source          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CNT_W  = $clog2(MAX_BOXES + 1);
    localparam int RING   = MAX_BOXES + PIPE_DEPTH;
    localparam int STEP_W = $clog2(RING);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(RING - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_BOXES);

    nms_state_t state_reg, state_next;

    logic [THR_W-1:0] thr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;

    // staging register for an accepted box
    logic             stg_valid_reg, stg_valid_next;
    nms_entry_t       stg_reg;
    logic             stg_store_reg, stg_last_reg;

    logic [STEP_W-1:0] step_reg, step_next;
    nms_entry_t        leader_reg;
    logic              found_reg, found_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]  pend_idx_reg;

    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic             out_any_reg, out_any_next;
    logic             out_ovf_reg, out_ovf_next;
    logic             out_last_reg, out_last_next;

    logic       accept, out_free, take_lead, adv;
    nms_entry_t new_entry, head, pipe_in, pipe_out;
    logic signed [COORD_W:0]  ext_x, ext_y;
    logic signed [AREA_W-1:0] new_area;

    nms_cell_ctl_t ctl;
    nms_entry_t    cell_q [MAX_BOXES];
    logic          keep   [MAX_BOXES];

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_OVERLAP) ? PDATA_W'(thr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_OVERLAP))
        begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // load side: hold one box in the staging register, insert it next cycle
    assign box.ready = (state_reg == ST_LOAD) && !stg_valid_reg;
    assign accept    = box.valid && box.ready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_reg.valid <= 1'b1;
            stg_reg.idx   <= IDX_W'(count_reg);
            stg_reg.score <= box.score;
            stg_reg.lx    <= box.left_x;
            stg_reg.ty    <= box.top_y;
            stg_reg.rx    <= box.right_x;
            stg_reg.by    <= box.bottom_y;
            stg_reg.area  <= '0;
            stg_store_reg <= (count_reg < CNT_MAX);
            stg_last_reg  <= box.last_box;
        end
    end

    // signed extents: corners inverted on one axis give a negative area, still kept
    always_comb
    begin
        ext_x     = $signed({1'b0, stg_reg.rx}) - $signed({1'b0, stg_reg.lx});
        ext_y     = $signed({1'b0, stg_reg.by}) - $signed({1'b0, stg_reg.ty});
        new_area  = ext_x * ext_y;
        new_entry      = stg_reg;
        new_entry.area = new_area;
    end

    // ring head and the leader pick
    assign head      = cell_q[0];
    assign out_free  = !out_valid_reg || result.ready;
    assign take_lead = (state_reg == ST_RUN) && head.valid && !found_reg;
    assign adv       = (state_reg == ST_RUN) && !(take_lead && pend_valid_reg && !out_free);

    always_comb
    begin
        pipe_in = head;
        if (take_lead)
        begin
            pipe_in.valid = 1'b0;
        end
        ctl.insert = stg_valid_reg && stg_store_reg && (new_area != '0);
        ctl.shift  = adv;
    end

    for (genvar i = 0; i < MAX_BOXES; i++)
    begin : g_cell
        nms_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .new_entry  (new_entry),
            .prev_entry ((i == 0) ? new_entry : cell_q[(i == 0) ? 0 : i - 1]),
            .prev_keep  ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i - 1]),
            .next_entry ((i == MAX_BOXES - 1) ? pipe_out
                                              : cell_q[(i == MAX_BOXES - 1) ? i : i + 1]),
            .entry      (cell_q[i]),
            .keep       (keep[i])
        );
    end

    nms_iou u_iou (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (adv),
        .threshold (thr_reg),
        .leader    (leader_reg),
        .head      (pipe_in),
        .tail      (pipe_out)
    );

    always_ff @(posedge clk)
    begin
        if (adv && take_lead)
        begin
            leader_reg   <= head;
            pend_idx_reg <= head.idx;
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        stg_valid_next  = stg_valid_reg;
        step_next       = step_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_idx_next    = out_idx_reg;
        out_any_next    = out_any_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    stg_valid_next = 1'b1;
                    if (count_reg < CNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                if (stg_valid_reg)
                begin
                    stg_valid_next = 1'b0;
                    if (stg_last_reg)
                    begin
                        state_next      = ST_RUN;
                        step_next       = '0;
                        found_next      = 1'b0;
                        pend_valid_next = 1'b0;
                    end
                end
            end
            ST_RUN:
            begin
                if (adv)
                begin
                    if (take_lead)
                    begin
                        found_next      = 1'b1;
                        pend_valid_next = 1'b1;
                        if (pend_valid_reg)
                        begin
                            // release the previous keeper, not the last one
                            out_valid_next = 1'b1;
                            out_idx_next   = pend_idx_reg;
                            out_any_next   = 1'b1;
                            out_ovf_next   = ovf_reg;
                            out_last_next  = 1'b0;
                        end
                    end
                    if (step_reg == STEP_LAST)
                    begin
                        step_next  = '0;
                        found_next = 1'b0;
                        if (!(found_reg || take_lead))
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_idx_next    = pend_valid_reg ? pend_idx_reg : '0;
                    out_any_next    = pend_valid_reg;
                    out_ovf_next    = ovf_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    state_next      = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            stg_valid_reg  <= 1'b0;
            step_reg       <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            stg_valid_reg  <= stg_valid_next;
            step_reg       <= step_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_idx_reg  <= out_idx_next;
        out_any_reg  <= out_any_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.kept_index  = out_idx_reg;
    assign result.any_kept    = out_any_reg;
    assign result.overflow    = out_ovf_reg;
    assign result.last_result = out_last_reg;

`ifndef ASSERT_OFF
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.any_kept) |-> result.last_result)
        else $error("empty result item not marked last");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("box count beyond capacity");

    a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == ST_FLUSH && state_reg == ST_LOAD) |->
        (count_reg == '0 && !ovf_reg && !pend_valid_reg))
        else $error("run state not cleared");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && !adv) |-> (out_valid_reg && !result.ready))
        else $error("ring held without a blocked output");
`endif

endmodule

### verif/nms_scoreboard.sv
`timescale 1ns / 1ps

class nms_scoreboard;
    typedef struct {
        logic [5:0] kept_index;
        logic       any_kept;
        logic       overflow;
        logic       last_result;
    } kept_t;

    logic [63:0] corners[64];
    logic [15:0] scores[64];
    int          n_loaded;
    bit          ovf_seen;
    logic [15:0] threshold;
    kept_t       pending[$];
    int          n_errors;
    int          n_checked;
    int          n_sets;

    function new();
        n_loaded  = 0;
        ovf_seen  = 0;
        threshold = nms_pkg::THR_RESET;
        n_errors  = 0;
        n_checked = 0;
        n_sets    = 0;
    endfunction

    function longint crn(logic [63:0] b, int k);
        return longint'(b[16*k +: 16]);
    endfunction

    function longint area_of(logic [63:0] b);
        return (crn(b, 2) - crn(b, 0)) * (crn(b, 3) - crn(b, 1));
    endfunction

    function bit overlaps(logic [63:0] a, logic [63:0] b);
        longint w, h, inter, uni;
        w = ((crn(a, 2) < crn(b, 2)) ? crn(a, 2) : crn(b, 2))
            - ((crn(a, 0) > crn(b, 0)) ? crn(a, 0) : crn(b, 0));
        h = ((crn(a, 3) < crn(b, 3)) ? crn(a, 3) : crn(b, 3))
            - ((crn(a, 1) > crn(b, 1)) ? crn(a, 1) : crn(b, 1));
        if (w < 0) w = 0;
        if (h < 0) h = 0;
        inter = w * h;
        uni = area_of(a) + area_of(b) - inter;
        if (uni < 0)
            return 0;
        return inter * 65536 > longint'(threshold) * uni;
    endfunction

    // note an accepted box; on the last one, run suppression
    function void note_box(logic [15:0] lx, logic [15:0] ty, logic [15:0] rx,
                           logic [15:0] by, logic [15:0] sc, logic lb);
        int    order[64];
        bit    alive[64];
        int    i, j, emitted;
        kept_t r;
        if (n_loaded < 64) begin
            corners[n_loaded] = {by, rx, ty, lx};
            scores[n_loaded]  = sc;
            n_loaded++;
        end
        else
            ovf_seen = 1;
        if (!lb)
            return;
        for (i = 0; i < n_loaded; i++) begin
            j = i;
            while (j > 0 && scores[order[j-1]] < scores[i]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (i = 0; i < n_loaded; i++)
            alive[i] = area_of(corners[order[i]]) != 0;
        for (i = 0; i < n_loaded; i++)
            if (alive[i])
                for (j = i + 1; j < n_loaded; j++)
                    if (alive[j] && overlaps(corners[order[i]], corners[order[j]]))
                        alive[j] = 0;
        emitted = 0;
        for (i = 0; i < n_loaded; i++)
            if (alive[i]) begin
                r.kept_index = order[i];
                r.any_kept = 1;
                r.overflow = ovf_seen;
                r.last_result = 0;
                pending = {pending, r};
                emitted++;
            end
        if (emitted == 0) begin
            r.kept_index = 0;
            r.any_kept = 0;
            r.overflow = ovf_seen;
            r.last_result = 1;
            pending = {pending, r};
        end
        else
            pending[pending.size()-1].last_result = 1;
        n_loaded = 0;
        ovf_seen = 0;
        n_sets++;
    endfunction

    function void check_result(kept_t got);
        kept_t want;
        if (pending.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
                $display("unexpected result: idx=%0d any=%0d ovf=%0d last=%0d",
                         got.kept_index, got.any_kept, got.overflow, got.last_result);
            return;
        end
        want = pending.pop_front();
        n_checked++;
        if (got.kept_index !== want.kept_index || got.any_kept !== want.any_kept ||
            got.overflow !== want.overflow || got.last_result !== want.last_result) begin
            n_errors++;
            if (n_errors <= 10)
                $display("mismatch: exp idx=%0d any=%0d ovf=%0d last=%0d, got idx=%0d any=%0d ovf=%0d last=%0d",
                         want.kept_index, want.any_kept, want.overflow, want.last_result,
                         got.kept_index, got.any_kept, got.overflow, got.last_result);
        end
    endfunction
endclass

### verif/non_maximum_suppression_unit_tb.sv
`timescale 1ns / 1ps

module non_maximum_suppression_unit_tb;
    import nms_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    nms_box_if box_ch ();
    nms_res_if res_ch ();

    non_maximum_suppression_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .box     (box_ch.sink),
        .result  (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    nms_scoreboard sb;
    longint unsigned cycle_count;
    bit   stim_done;
    int   n_boxes;
    localparam longint unsigned CYCLE_LIMIT = 3000000;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // watchdog: fails the test once the cycle count passes CYCLE_LIMIT, a bound for all sets
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("non_maximum_suppression_unit_tb NOT OK");
            $finish;
        end
    end

    // sample both channels at the edge; note accepted boxes, check accepted results
    always @(posedge clk)
    begin
        if (rst_n && box_ch.valid && box_ch.ready)
            sb.note_box(box_ch.left_x, box_ch.top_y, box_ch.right_x,
                        box_ch.bottom_y, box_ch.score, box_ch.last_box);
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result('{res_ch.kept_index, res_ch.any_kept,
                              res_ch.overflow, res_ch.last_result});
    end

    // result side: random stalls, with stretches of no stall at all
    initial
    begin
        int hold;
        int calm;
        res_ch.ready = 0;
        calm = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (calm > 0)
            begin
                calm--;
                res_ch.ready <= 1;
            end
            else if ($urandom_range(0, 29) == 0)
                calm = $urandom_range(20, 200);
            else
            begin
                hold = gap_len();
                if (hold > 0)
                begin
                    res_ch.ready <= 0;
                    repeat (hold - 1) @(posedge clk);
                    @(posedge clk);
                end
                res_ch.ready <= 1;
            end
        end
    end

    task automatic apb_write(logic [PADDR_W-1:0] a, logic [PDATA_W-1:0] d);
        @(posedge clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        sb.threshold = d[15:0];
    endtask

    // send one box; hold valid until ready, insert a random gap first when gaps is set
    task automatic send_box(logic [15:0] lx, logic [15:0] ty, logic [15:0] rx,
                            logic [15:0] by, logic [15:0] sc, logic lb, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            box_ch.valid <= 0;
            repeat (g) @(posedge clk);
        end
        box_ch.valid    <= 1;
        box_ch.left_x   <= lx;
        box_ch.top_y    <= ty;
        box_ch.right_x  <= rx;
        box_ch.bottom_y <= by;
        box_ch.score    <= sc;
        box_ch.last_box <= lb;
        do
            @(posedge clk);
        while (!box_ch.ready);
        n_boxes++;
    endtask

    task automatic idle_box();
        box_ch.valid <= 0;
    endtask

    // drain: let the last box be noted, wait for all expected items, then the tail
    task automatic drain();
        idle_box();
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4 * (MAX_BOXES_DEF + 4) + 20) @(posedge clk);
    endtask

    // random box: near a centre so IoU nears the threshold; some random or zero-width
    task automatic rand_box(int cx, int cy, logic lb, bit gaps);
        logic [15:0] lx, ty, rx, by, sc;
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            lx = $urandom; ty = $urandom; rx = $urandom; by = $urandom;
        end
        else
        begin
            lx = 16'(cx + $urandom_range(0, 60));
            ty = 16'(cy + $urandom_range(0, 60));
            rx = 16'(lx + $urandom_range(0, 120));
            by = 16'(ty + $urandom_range(0, 120));
            if (r == 1) rx = lx;
        end
        sc = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
        send_box(lx, ty, rx, by, sc, lb, gaps);
    endtask

    task automatic rand_set(int count, bit gaps);
        int cx[4], cy[4], k, c;
        for (k = 0; k < 4; k++)
        begin
            cx[k] = $urandom_range(0, 65000);
            cy[k] = $urandom_range(0, 65000);
        end
        for (k = 0; k < count; k++)
        begin
            c = $urandom_range(0, 3);
            rand_box(cx[c], cy[c], k == count - 1, gaps);
        end
    endtask

    initial
    begin
        int k;
        sb = new();
        cycle_count = 0;
        n_boxes = 0;
        stim_done = 0;
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = ADDR_OVERLAP; pwdata = 0;
        box_ch.valid = 0; box_ch.left_x = 0; box_ch.top_y = 0; box_ch.right_x = 0;
        box_ch.bottom_y = 0; box_ch.score = 0; box_ch.last_box = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;

        // directed: single box at the field extremes, kept at reset threshold
        send_box(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0);
        drain();
        // zero-area last box only: empty result
        send_box(16'd5, 16'd5, 16'd5, 16'd90, 16'd0, 1, 0);
        drain();
        // inverted corners (negative extents), identical boxes, equal scores
        send_box(16'd100, 16'd100, 16'd10, 16'd10, 16'd7, 0, 0);
        send_box(16'd100, 16'd100, 16'd10, 16'd10, 16'd7, 0, 0);
        send_box(16'd10, 16'd10, 16'd100, 16'd100, 16'd7, 0, 0);
        send_box(16'd10, 16'd10, 16'd100, 16'd100, 16'd7, 1, 0);
        drain();
        // threshold extremes: zero suppresses any overlap, max nearly none
        apb_write(ADDR_OVERLAP, 32'h0000_0000);
        send_box(16'd0, 16'd0, 16'd40, 16'd40, 16'h8000, 0, 0);
        send_box(16'd39, 16'd39, 16'd80, 16'd80, 16'h9000, 0, 0);
        send_box(16'd40, 16'd40, 16'd80, 16'd80, 16'h1000, 1, 0);
        drain();
        apb_write(ADDR_OVERLAP, 32'h0000_FFFF);
        send_box(16'd0, 16'd0, 16'd40, 16'd40, 16'h8000, 0, 0);
        send_box(16'd0, 16'd0, 16'd40, 16'd40, 16'h8000, 1, 0);
        drain();
        // overflow: 66 boxes, the last two dropped
        apb_write(ADDR_OVERLAP, 32'(THR_RESET));
        for (k = 0; k < 66; k++)
            send_box(16'(k * 50), 16'd0, 16'(k * 50 + 30), 16'd30,
                     16'(k), k == 65, 0);
        drain();

        // random sets at several thresholds, mostly small
        while (n_boxes < 280)
        begin
            k = $urandom_range(0, 9);
            if (k == 0)
                apb_write(ADDR_OVERLAP, 32'($urandom_range(0, 65535)));
            else if (k == 1)
                apb_write(ADDR_OVERLAP, 32'($urandom_range(0, 1) ? 65535 : 0));
            else if (k == 2)
                apb_write(ADDR_OVERLAP, 32'($urandom_range(16000, 50000)));
            rand_set(($urandom_range(0, 12) == 0) ? $urandom_range(30, 68)
                                                  : $urandom_range(1, 10),
                     $urandom_range(0, 3) != 0);
            drain();
        end

        $display("covered %0d boxes in %0d sets, %0d results checked",
                 n_boxes, sb.n_sets, sb.n_checked);
        if (sb.n_errors == 0 && sb.pending.size() == 0)
            $display("non_maximum_suppression_unit_tb OK");
        else
        begin
            $display("%0d mismatches", sb.n_errors);
            $display("non_maximum_suppression_unit_tb NOT OK");
        end
        $finish;
    end
endmodule
